FILE: src/ppd_pkg.sv
// Shared constants and codes for the polyline projection distance block.
`timescale 1ns / 1ps
package ppd_pkg;
	localparam int COORD_W  = 32;
	localparam int DIST_W   = 32;
	localparam int COUNT_W  = 9;
	localparam int INDEX_W  = 8;
	localparam int CFG_IDX_W = 1;
	localparam int ALPHA_W  = 17;
	localparam int LEN_W    = 66;
	localparam int REM_W    = 67;
	localparam int ERR_W    = 51;
	localparam int MAG_W    = 50;
	localparam int HALF_W   = 25;
	localparam int OPND_W   = 34;
	localparam int PROD_W   = 68;
	localparam int ACC_W    = 104;
	localparam int D2_W     = 102;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE    = 17'h10000;
	localparam logic [LEN_W-1:0]   SMALL_LEN_SQ = 66'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_LENGTH = 1'b1;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;
endpackage

FILE: src/ppd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ppd_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: src/polyline_projection_distance.sv
// Top level: closest point on a stored 2D polyline, returning the route distance.
//
//  channel | signals                                           | direction
//  in      | in_valid in_ready kind entry_index point_x/_y      | request in
//          | sample_distance                                   |
//  out     | out_valid out_ready valid_res distance_along      | request out
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data            | register write
//
// A load request is written to the sample RAM when accepted, if its index is in range. A query walks
// each segment through the shared 34x34 multiplier and, at most once per segment, the 16-step alpha divider.
// Samples sit in one RAM; consecutive entries are read one per segment.
// Reset clears control, config and output registers only; table contents stay undefined until loaded.
// A finished result waits in ST_DONE until the output register is free; a query only stalls on completion.
`timescale 1ns / 1ps
module polyline_projection_distance #(
	parameter int MAX_SAMPLES = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic [ppd_pkg::INDEX_W-1:0]     entry_index,
	input  logic signed [ppd_pkg::COORD_W-1:0] point_x,
	input  logic signed [ppd_pkg::COORD_W-1:0] point_y,
	input  logic [ppd_pkg::DIST_W-1:0]      sample_distance,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            valid_res,
	output logic [ppd_pkg::DIST_W-1:0]      distance_along,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ppd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data
);
	import ppd_pkg::*;

	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;
	localparam int RW = 2 * COORD_W + DIST_W;

	localparam logic [4:0] ST_IDLE = 5'd0,  ST_RD0 = 5'd1,  ST_RD = 5'd2,
		ST_M1 = 5'd3,  ST_M2 = 5'd4,  ST_M3 = 5'd5,  ST_M4 = 5'd6,  ST_M5 = 5'd7,
		ST_DEC = 5'd8, ST_DIV = 5'd9, ST_E1 = 5'd10, ST_E2 = 5'd11, ST_E3 = 5'd12,
		ST_Q1 = 5'd13, ST_Q2 = 5'd14, ST_Q3 = 5'd15, ST_Q4 = 5'd16, ST_Q5 = 5'd17,
		ST_Q6 = 5'd18, ST_Q7 = 5'd19, ST_CMP = 5'd20, ST_L2 = 5'd21, ST_L3 = 5'd22,
		ST_L4 = 5'd23, ST_NEXT = 5'd24, ST_DONE = 5'd25;

	logic [4:0]                state_q;
	logic [COUNT_W-1:0]        sample_count_q;
	logic [DIST_W-1:0]         route_length_q;
	logic [CW-1:0]             n_q, i_q, n_w, i_next;
	logic signed [COORD_W-1:0] qx_q, qy_q, prev_x_q, prev_y_q;
	logic [DIST_W-1:0]         d0_q, d1_q;
	logic signed [COORD_W:0]   dx_q, dy_q, px_q, py_q;
	logic [LEN_W-1:0]          len_q;
	logic [REM_W-1:0]          rem_q;
	logic [ALPHA_W-1:0]        a_q;
	logic [3:0]                div_cnt_q;
	logic signed [ERR_W-1:0]   ex_q, ey_q;
	logic [ERR_W-1:0]          exa, eya;
	logic [MAG_W-1:0]          exm, eym;
	logic signed [OPND_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic [ACC_W-1:0]          acc_q, acc_term;
	logic                      acc_en_q, acc_clr_q, acc_en_d, acc_clr_d;
	logic [5:0]                acc_sh_q, acc_sh_d;
	logic [D2_W-1:0]           best_q;
	logic                      have_q, better;
	logic [DIST_W-1:0]         best_dist_q, res_dist_q;
	logic                      res_valid_q;
	logic                      out_valid_q, valid_res_q;
	logic [DIST_W-1:0]         distance_q;
	logic                      res_load;
	logic [REM_W:0]            rem2;
	logic                      rem_ge;
	logic [DIST_W+ALPHA_W+1:0] lerp_round;
	logic [IW-1:0]             idx_ext;
	logic                      ram_we;
	logic [AW-1:0]             ram_raddr;
	logic [RW-1:0]             ram_rdata;
	logic signed [COORD_W-1:0] rd_x, rd_y;
	logic [DIST_W-1:0]         rd_d;
	logic                      in_acc;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign valid_res = valid_res_q;
	assign distance_along = distance_q;
	assign in_acc    = in_valid && in_ready;
	assign res_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign idx_ext = IW'(entry_index);
	assign ram_we  = in_acc && (kind == KIND_LOAD)
		&& ({1'b0, idx_ext} < (IW+1)'(MAX_SAMPLES));
	assign n_w     = (sample_count_q > MAX_SAMPLES) ? CW'(MAX_SAMPLES) : CW'(sample_count_q);
	assign i_next  = i_q + CW'(1);

	always_comb begin
		case (state_q)
			ST_RD0:  ram_raddr = AW'(1);
			ST_NEXT: ram_raddr = i_next[AW-1:0];
			default: ram_raddr = '0;
		endcase
	end

	ppd_ram #(.WIDTH(RW), .DEPTH(MAX_SAMPLES)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_ext[AW-1:0]),
		.wdata ({point_x, point_y, sample_distance}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_x = ram_rdata[RW-1 -: COORD_W];
	assign rd_y = ram_rdata[DIST_W +: COORD_W];
	assign rd_d = ram_rdata[DIST_W-1:0];

	assign exa = ex_q[ERR_W-1] ? ERR_W'(-ex_q) : ex_q;
	assign eya = ey_q[ERR_W-1] ? ERR_W'(-ey_q) : ey_q;
	assign exm = exa[MAG_W-1:0];
	assign eym = eya[MAG_W-1:0];

	assign better = !have_q || (acc_q[D2_W-1:0] < best_q);

	// operand select and accumulate control for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		acc_en_d = 1'b0;
		acc_clr_d = 1'b0;
		acc_sh_d = 6'd0;
		case (state_q)
			ST_M1: begin
				mul_a = OPND_W'(dx_q); mul_b = OPND_W'(dx_q);
				acc_en_d = 1'b1; acc_clr_d = 1'b1;
			end
			ST_M2: begin
				mul_a = OPND_W'(dy_q); mul_b = OPND_W'(dy_q);
				acc_en_d = 1'b1;
			end
			ST_M3: begin
				mul_a = OPND_W'(px_q); mul_b = OPND_W'(dx_q);
				acc_en_d = 1'b1; acc_clr_d = 1'b1;
			end
			ST_M4: begin
				mul_a = OPND_W'(py_q); mul_b = OPND_W'(dy_q);
				acc_en_d = 1'b1;
			end
			ST_E1: begin
				mul_a = OPND_W'(dx_q); mul_b = $signed({{(OPND_W-ALPHA_W){1'b0}}, a_q});
			end
			ST_E2: begin
				mul_a = OPND_W'(dy_q); mul_b = $signed({{(OPND_W-ALPHA_W){1'b0}}, a_q});
			end
			ST_Q1: begin
				mul_a = $signed(OPND_W'(exm[MAG_W-1:HALF_W]));
				mul_b = $signed(OPND_W'(exm[MAG_W-1:HALF_W]));
				acc_en_d = 1'b1; acc_clr_d = 1'b1; acc_sh_d = 6'(2 * HALF_W);
			end
			ST_Q2: begin
				mul_a = $signed(OPND_W'(exm[MAG_W-1:HALF_W]));
				mul_b = $signed(OPND_W'(exm[HALF_W-1:0]));
				acc_en_d = 1'b1; acc_sh_d = 6'(HALF_W + 1);
			end
			ST_Q3: begin
				mul_a = $signed(OPND_W'(exm[HALF_W-1:0]));
				mul_b = $signed(OPND_W'(exm[HALF_W-1:0]));
				acc_en_d = 1'b1;
			end
			ST_Q4: begin
				mul_a = $signed(OPND_W'(eym[MAG_W-1:HALF_W]));
				mul_b = $signed(OPND_W'(eym[MAG_W-1:HALF_W]));
				acc_en_d = 1'b1; acc_sh_d = 6'(2 * HALF_W);
			end
			ST_Q5: begin
				mul_a = $signed(OPND_W'(eym[MAG_W-1:HALF_W]));
				mul_b = $signed(OPND_W'(eym[HALF_W-1:0]));
				acc_en_d = 1'b1; acc_sh_d = 6'(HALF_W + 1);
			end
			ST_Q6: begin
				mul_a = $signed(OPND_W'(eym[HALF_W-1:0]));
				mul_b = $signed(OPND_W'(eym[HALF_W-1:0]));
				acc_en_d = 1'b1;
			end
			ST_CMP: begin
				mul_a = $signed(OPND_W'(d0_q));
				mul_b = $signed(OPND_W'(ALPHA_ONE - a_q));
				acc_en_d = better; acc_clr_d = 1'b1;
			end
			ST_L2: begin
				mul_a = $signed(OPND_W'(d1_q));
				mul_b = $signed({{(OPND_W-ALPHA_W){1'b0}}, a_q});
				acc_en_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign acc_term = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q} << acc_sh_q;

	assign rem2   = {rem_q, 1'b0};
	assign rem_ge = rem2 >= (REM_W+1)'(len_q);
	assign lerp_round = (DIST_W+ALPHA_W+2)'(acc_q[DIST_W+ALPHA_W:0]) + (DIST_W+ALPHA_W+2)'(32768);

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (acc_en_q) begin
			acc_q <= (acc_clr_q ? '0 : acc_q) + acc_term;
		end
		case (state_q)
			ST_IDLE: begin
				qx_q <= point_x;
				qy_q <= point_y;
				n_q  <= n_w;
			end
			ST_RD0: begin
				prev_x_q <= rd_x;
				prev_y_q <= rd_y;
				d1_q     <= rd_d;
				i_q      <= CW'(1);
			end
			ST_RD: begin
				dx_q <= {rd_x[COORD_W-1], rd_x} - {prev_x_q[COORD_W-1], prev_x_q};
				dy_q <= {rd_y[COORD_W-1], rd_y} - {prev_y_q[COORD_W-1], prev_y_q};
				px_q <= {qx_q[COORD_W-1], qx_q} - {prev_x_q[COORD_W-1], prev_x_q};
				py_q <= {qy_q[COORD_W-1], qy_q} - {prev_y_q[COORD_W-1], prev_y_q};
				d0_q <= d1_q;
				d1_q <= rd_d;
				prev_x_q <= rd_x;
				prev_y_q <= rd_y;
			end
			ST_M4: len_q <= acc_q[LEN_W-1:0];
			ST_DEC: begin
				a_q <= '0;
				div_cnt_q <= '0;
				rem_q <= acc_q[REM_W-1:0];
				if (len_q > SMALL_LEN_SQ && !($signed(acc_q) <= 0)
					&& acc_q[REM_W-1:0] >= REM_W'(len_q)) begin
					a_q <= ALPHA_ONE;
				end
			end
			ST_DIV: begin
				rem_q <= rem_ge ? REM_W'(rem2 - (REM_W+1)'(len_q)) : rem2[REM_W-1:0];
				a_q <= {a_q[ALPHA_W-2:0], rem_ge};
				div_cnt_q <= div_cnt_q + 4'd1;
			end
			ST_E2: ex_q <= {{2{px_q[COORD_W]}}, px_q, 16'h0} - prod_q[ERR_W-1:0];
			ST_E3: ey_q <= {{2{py_q[COORD_W]}}, py_q, 16'h0} - prod_q[ERR_W-1:0];
			ST_CMP: begin
				if (better) begin
					best_q <= acc_q[D2_W-1:0];
				end
			end
			ST_L4: best_dist_q <= lerp_round[DIST_W+15:16];
			ST_NEXT: i_q <= i_next;
			default: begin
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sample_count_q <= '0;
			route_length_q <= '0;
			acc_en_q       <= 1'b0;
			acc_clr_q      <= 1'b0;
			acc_sh_q       <= '0;
			have_q         <= 1'b0;
			res_valid_q    <= 1'b0;
			res_dist_q     <= '0;
			out_valid_q    <= 1'b0;
			valid_res_q    <= 1'b0;
			distance_q     <= '0;
		end else begin
			acc_en_q  <= acc_en_d;
			acc_clr_q <= acc_clr_d;
			acc_sh_q  <= acc_sh_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SAMPLE_COUNT: sample_count_q <= cfg_data[COUNT_W-1:0];
					CFG_ROUTE_LENGTH: route_length_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && kind == KIND_QUERY) begin
						have_q <= 1'b0;
						if (route_length_q == '0 || n_w < CW'(2)) begin
							res_valid_q <= 1'b0;
							res_dist_q  <= '0;
							state_q     <= ST_DONE;
						end else begin
							state_q <= ST_RD0;
						end
					end
				end
				ST_RD0: state_q <= ST_RD;
				ST_RD:  state_q <= ST_M1;
				ST_M1:  state_q <= ST_M2;
				ST_M2:  state_q <= ST_M3;
				ST_M3:  state_q <= ST_M4;
				ST_M4:  state_q <= ST_M5;
				ST_M5:  state_q <= ST_DEC;
				ST_DEC: begin
					if (len_q > SMALL_LEN_SQ && !($signed(acc_q) <= 0)
						&& acc_q[REM_W-1:0] < REM_W'(len_q)) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_E1;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == 4'd15) begin
						state_q <= ST_E1;
					end
				end
				ST_E1: state_q <= ST_E2;
				ST_E2: state_q <= ST_E3;
				ST_E3: state_q <= ST_Q1;
				ST_Q1: state_q <= ST_Q2;
				ST_Q2: state_q <= ST_Q3;
				ST_Q3: state_q <= ST_Q4;
				ST_Q4: state_q <= ST_Q5;
				ST_Q5: state_q <= ST_Q6;
				ST_Q6: state_q <= ST_Q7;
				ST_Q7: state_q <= ST_CMP;
				ST_CMP: begin
					if (better) begin
						have_q  <= 1'b1;
						state_q <= ST_L2;
					end else begin
						state_q <= ST_NEXT;
					end
				end
				ST_L2: state_q <= ST_L3;
				ST_L3: state_q <= ST_L4;
				ST_L4: state_q <= ST_NEXT;
				ST_NEXT: begin
					if (i_next == n_q) begin
						res_valid_q <= 1'b1;
						res_dist_q  <= best_dist_q;
						state_q     <= ST_DONE;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						valid_res_q <= res_valid_q;
						distance_q  <= res_dist_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: src/ppd_checker.sv
// Port-level checks for the polyline projection distance block, bound to the top level.
`timescale 1ns / 1ps
module ppd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        kind,
	input logic        out_valid,
	input logic        out_ready,
	input logic        valid_res,
	input logic [31:0] distance_along
);
	import ppd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance_along) && $stable(valid_res))
		else $error("result changed while stalled");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> distance_along == 32'd0)
		else $error("invalid result carries a distance");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == KIND_QUERY |=> !in_ready)
		else $error("query request did not occupy the block");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == KIND_LOAD |=> in_ready)
		else $error("load request stalled the input");
endmodule

bind polyline_projection_distance ppd_checker u_ppd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.kind           (kind),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.valid_res      (valid_res),
	.distance_along (distance_along)
);
